### rtl/desu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline event scheduler package
// Shared constants, controller states and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package desu_pkg;

  localparam int unsigned EventSlotsDefault = 8;
  localparam int unsigned MaxResults = 8;
  localparam logic [31:0] EarlyWindowReset = 32'd100000;

  localparam int unsigned FireIdxW = $clog2(MaxResults);
  localparam int unsigned FireCntW = $clog2(MaxResults + 1);

  localparam logic KindRegister = 1'b0;
  localparam logic KindTick = 1'b1;
  localparam logic StatusOk = 1'b0;
  localparam logic StatusFull = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_CALC,
    ST_REG_ACK,
    ST_TICK_CALC,
    ST_SCAN,
    ST_EMIT,
    ST_ARM_CALC,
    ST_ARM_INS
  } desu_state_e;

  typedef struct packed {
    logic latch_in;
    logic calc_reg;
    logic calc_limit;
    logic pop_record;
    logic load_ack;
    logic load_wake;
    logic calc_arm;
    logic arm_insert;
    logic idx_inc;
  } desu_cmd_t;

  typedef struct packed {
    logic due;
    logic fire_empty;
    logic emit_last;
    logic emit_periodic;
    logic out_free;
  } desu_sts_t;

endpackage

### rtl/desu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline event scheduler controller
// Sequences register, expiry scan, wakeup and re-arm steps for one item.
// ----------------------------------------------------------------------------
module desu_ctrl
  import desu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      kind_i,
  output logic      in_stall_o,
  input  desu_sts_t sts_i,
  output desu_cmd_t cmd_o
);

  desu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = (kind_i == KindTick) ? ST_TICK_CALC : ST_REG_CALC;
        end
      end
      ST_REG_CALC: begin
        cmd_o.calc_reg = 1'b1;
        state_d = ST_REG_ACK;
      end
      ST_REG_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.load_ack = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_TICK_CALC: begin
        cmd_o.calc_limit = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.due) begin
          cmd_o.pop_record = 1'b1;
        end else if (sts_i.fire_empty) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_wake = 1'b1;
          if (sts_i.emit_periodic) begin
            state_d = ST_ARM_CALC;
          end else if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_ARM_CALC: begin
        cmd_o.calc_arm = 1'b1;
        state_d = ST_ARM_INS;
      end
      ST_ARM_INS: begin
        cmd_o.arm_insert = 1'b1;
        if (sts_i.emit_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = ST_EMIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/desu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline event scheduler datapath
// Sorted event table as a row of cells, fired-event buffer, adders and the
// output register.
// ----------------------------------------------------------------------------
module desu_dp
  import desu_pkg::*;
#(
  parameter int unsigned EventSlots = EventSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        early_window_we_i,
  input  logic [31:0] early_window_i,
  input  logic [3:0]  client_id_i,
  input  logic [31:0] delay_us_i,
  input  logic [31:0] period_us_i,
  input  logic [63:0] now_us_i,
  input  desu_cmd_t   cmd_i,
  output desu_sts_t   sts_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [3:0]  woken_client_o,
  output logic        status_o,
  output logic        last_o
);

  localparam int unsigned CntW = $clog2(EventSlots + 1);

  logic [31:0] early_window_q;
  logic [63:0] now_q;
  logic [31:0] delay_q;
  logic [31:0] period_q;
  logic [3:0]  client_q;
  logic [63:0] limit_q, limit_d;
  logic [64:0] limit_sum;
  logic [63:0] new_dl_q, new_dl_d;
  logic [31:0] new_per_q, new_per_d;
  logic [3:0]  new_cli_q, new_cli_d;

  logic [63:0] dl_q  [EventSlots];
  logic [31:0] per_q [EventSlots];
  logic [3:0]  cli_q [EventSlots];
  logic [CntW-1:0] count_q, count_d;
  logic [EventSlots-1:0] le;
  logic full;
  logic insert;
  logic pop;

  logic [31:0] fire_per_q [MaxResults];
  logic [3:0]  fire_cli_q [MaxResults];
  logic [FireCntW-1:0] fire_cnt_q, fire_cnt_d;
  logic [FireIdxW-1:0] emit_idx_q, emit_idx_d;
  logic [31:0] emit_per;
  logic [3:0]  emit_cli;

  logic out_valid_q, out_valid_d;
  logic out_kind_q, out_status_q, out_last_q;
  logic [3:0] out_cli_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_window_q <= EarlyWindowReset;
    end else if (early_window_we_i) begin
      early_window_q <= early_window_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      now_q    <= now_us_i;
      delay_q  <= delay_us_i;
      period_q <= period_us_i;
      client_q <= client_id_i;
    end
  end

  assign full = (count_q == CntW'(EventSlots));
  assign insert = (cmd_i.load_ack || cmd_i.arm_insert) && !full;
  assign pop = cmd_i.pop_record;

  assign emit_per = fire_per_q[emit_idx_q];
  assign emit_cli = fire_cli_q[emit_idx_q];

  assign limit_sum = {1'b0, now_q} + {33'd0, early_window_q};

  always_comb begin
    limit_d   = limit_q;
    new_dl_d  = new_dl_q;
    new_per_d = new_per_q;
    new_cli_d = new_cli_q;
    if (cmd_i.calc_limit) begin
      limit_d = limit_sum[64] ? '1 : limit_sum[63:0];
    end
    if (cmd_i.calc_reg) begin
      new_dl_d  = now_q + {32'd0, delay_q};
      new_per_d = period_q;
      new_cli_d = client_q;
    end else if (cmd_i.calc_arm) begin
      new_dl_d  = now_q + {32'd0, emit_per};
      new_per_d = emit_per;
      new_cli_d = emit_cli;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q   <= limit_d;
    new_dl_q  <= new_dl_d;
    new_per_q <= new_per_d;
    new_cli_q <= new_cli_d;
  end

  for (genvar i = 0; i < EventSlots; i++) begin : g_cell
    logic        prev_le;
    logic [63:0] prv_dl, nxt_dl, dl_d;
    logic [31:0] prv_per, nxt_per, per_d;
    logic [3:0]  prv_cli, nxt_cli, cli_d;

    assign le[i] = (count_q > CntW'(i)) && (dl_q[i] <= new_dl_q);

    if (i == 0) begin : g_head
      assign prev_le = 1'b1;
      assign prv_dl  = dl_q[i];
      assign prv_per = per_q[i];
      assign prv_cli = cli_q[i];
    end else begin : g_body
      assign prev_le = le[i-1];
      assign prv_dl  = dl_q[i-1];
      assign prv_per = per_q[i-1];
      assign prv_cli = cli_q[i-1];
    end

    if (i == EventSlots - 1) begin : g_tail
      assign nxt_dl  = dl_q[i];
      assign nxt_per = per_q[i];
      assign nxt_cli = cli_q[i];
    end else begin : g_inner
      assign nxt_dl  = dl_q[i+1];
      assign nxt_per = per_q[i+1];
      assign nxt_cli = cli_q[i+1];
    end

    always_comb begin
      dl_d  = dl_q[i];
      per_d = per_q[i];
      cli_d = cli_q[i];
      if (insert) begin
        if (!le[i] && prev_le) begin
          dl_d  = new_dl_q;
          per_d = new_per_q;
          cli_d = new_cli_q;
        end else if (!le[i]) begin
          dl_d  = prv_dl;
          per_d = prv_per;
          cli_d = prv_cli;
        end
      end else if (pop) begin
        dl_d  = nxt_dl;
        per_d = nxt_per;
        cli_d = nxt_cli;
      end
    end

    always_ff @(posedge clk_i) begin
      dl_q[i]  <= dl_d;
      per_q[i] <= per_d;
      cli_q[i] <= cli_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (insert) begin
      count_d = count_q + CntW'(1);
    end else if (pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    fire_cnt_d = fire_cnt_q;
    emit_idx_d = emit_idx_q;
    if (cmd_i.calc_limit) begin
      fire_cnt_d = '0;
      emit_idx_d = '0;
    end else if (pop) begin
      fire_cnt_d = fire_cnt_q + FireCntW'(1);
    end else if (cmd_i.idx_inc) begin
      emit_idx_d = emit_idx_q + FireIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      fire_cnt_q <= '0;
      emit_idx_q <= '0;
    end else begin
      count_q    <= count_d;
      fire_cnt_q <= fire_cnt_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      fire_per_q[fire_cnt_q[FireIdxW-1:0]] <= per_q[0];
      fire_cli_q[fire_cnt_q[FireIdxW-1:0]] <= cli_q[0];
    end
  end

  assign sts_o.due = (count_q != '0) && (fire_cnt_q != FireCntW'(MaxResults))
                     && (dl_q[0] <= limit_q);
  assign sts_o.fire_empty = (fire_cnt_q == '0);
  assign sts_o.emit_last = (FireCntW'(emit_idx_q) + FireCntW'(1) == fire_cnt_q);
  assign sts_o.emit_periodic = (emit_per != '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_ack || cmd_i.load_wake) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ack) begin
      out_kind_q   <= KindRegister;
      out_cli_q    <= client_q;
      out_status_q <= full ? StatusFull : StatusOk;
      out_last_q   <= 1'b1;
    end else if (cmd_i.load_wake) begin
      out_kind_q   <= KindTick;
      out_cli_q    <= emit_cli;
      out_status_q <= StatusOk;
      out_last_q   <= sts_o.emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign woken_client_o = out_cli_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

endmodule

### rtl/deadline_event_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline event scheduler unit
// Timer event table kept sorted by deadline, with wakeup and re-arm on ticks.
// ----------------------------------------------------------------------------
// The unit takes one item at a time. A register item passes through the
// calc and acknowledge states and answers with one acknowledge. A tick
// item forms its wake limit, pops due events (at most eight), then emits
// one wakeup per woken event and re-arms each periodic one; a tick that
// wakes nothing emits nothing. The table inserts or removes one entry per
// cycle, and a 64-bit adder forms one deadline per cycle.
// A result waits in the output register while the next item is accepted.
module deadline_event_scheduler_unit
  import desu_pkg::*;
#(
  parameter int unsigned EVENT_SLOTS = EventSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        early_window_we_i,
  input  logic [31:0] early_window_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [3:0]  client_id_i,
  input  logic [31:0] delay_us_i,
  input  logic [31:0] period_us_i,
  input  logic [63:0] now_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [3:0]  woken_client_o,
  output logic        status_o,
  output logic        last_o
);

  desu_cmd_t cmd;
  desu_sts_t sts;

  desu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  desu_dp #(
    .EventSlots (EVENT_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .early_window_we_i (early_window_we_i),
    .early_window_i    (early_window_i),
    .client_id_i       (client_id_i),
    .delay_us_i        (delay_us_i),
    .period_us_i       (period_us_i),
    .now_us_i          (now_us_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .woken_client_o    (woken_client_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

endmodule

### rtl/desu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline event scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module desu_checker
  import desu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       result_kind_o,
  input logic [3:0] woken_client_o,
  input logic       status_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(woken_client_o) && $stable(status_o) && $stable(last_o))
    else $error("A stalled result item changed.");

  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KindTick) |-> (status_o == StatusOk))
    else $error("A wakeup item carries a full status.");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KindRegister) |-> last_o)
    else $error("An acknowledge item is not marked last.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("A second item was accepted right after the first.");

endmodule

bind deadline_event_scheduler_unit desu_checker u_desu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_kind_o  (result_kind_o),
  .woken_client_o (woken_client_o),
  .status_o       (status_o),
  .last_o         (last_o)
);

### sim/deadline_event_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline event scheduler unit test
// Drives register and tick items into the scheduler and keeps its own copy of
// the sorted event table. Every acknowledge and wakeup that leaves the unit is
// checked field by field against the notices that the table copy predicts.
// The run covers deadline wrap, window saturation, a full table, ties and
// re-arming, under several early window settings and random stalls.
// ----------------------------------------------------------------------------
module deadline_event_scheduler_unit_test;
  import desu_pkg::*;

  localparam int unsigned TableSlots = 8;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldCycles = 80;
  localparam logic ResultAck = 1'b0;
  localparam logic ResultWake = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  client;
    logic [31:0] delay;
    logic [31:0] period;
    logic [63:0] now;
  } sched_req_t;

  typedef struct packed {
    logic       rkind;
    logic [3:0] client;
    logic       status;
    logic       last;
  } notice_t;

  logic        clk_i;
  logic        rst_ni;
  logic        window_we;
  logic [31:0] window_data;
  logic        in_valid;
  logic        in_stall_o;
  sched_req_t  cur_req;
  logic        out_valid_o;
  logic        out_stall;
  logic        result_kind_o;
  logic [3:0]  woken_client_o;
  logic        status_o;
  logic        last_o;

  sched_req_t  request_q[$];
  notice_t     notice_q[$];
  sched_req_t  next_req;
  notice_t     head_notice;

  logic [63:0] ev_deadline[TableSlots];
  logic [31:0] ev_period[TableSlots];
  logic [3:0]  ev_client[TableSlots];
  int          ev_count;
  logic [31:0] cfg_window;

  int          mismatches;
  int          send_gap;
  int          stall_left;
  int          hold_left;
  int          idle_count;
  logic        hold_req;
  logic        calm;

  deadline_event_scheduler_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .early_window_we_i(window_we),
    .early_window_i   (window_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .kind_i           (cur_req.kind),
    .client_id_i      (cur_req.client),
    .delay_us_i       (cur_req.delay),
    .period_us_i      (cur_req.period),
    .now_us_i         (cur_req.now),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .result_kind_o    (result_kind_o),
    .woken_client_o   (woken_client_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void insert_event(logic [63:0] deadline, logic [31:0] period,
                                       logic [3:0] client);
    int pos;
    int j;
    pos = 0;
    while (pos < ev_count && ev_deadline[pos] <= deadline) pos++;
    for (j = ev_count; j > pos; j--) begin
      ev_deadline[j] = ev_deadline[j-1];
      ev_period[j] = ev_period[j-1];
      ev_client[j] = ev_client[j-1];
    end
    ev_deadline[pos] = deadline;
    ev_period[pos] = period;
    ev_client[pos] = client;
    ev_count++;
  endfunction

  function automatic void run_event_table(sched_req_t req);
    logic [63:0] wake_limit;
    logic [31:0] fired_period[MaxResults];
    logic [3:0]  fired_client[MaxResults];
    int          k;
    int          j;
    if (req.kind == KindRegister) begin
      if (ev_count >= TableSlots) begin
        notice_q.push_back('{ResultAck, req.client, StatusFull, 1'b1});
      end else begin
        insert_event(req.now + 64'(req.delay), req.period, req.client);
        notice_q.push_back('{ResultAck, req.client, StatusOk, 1'b1});
      end
    end else begin
      wake_limit = req.now + 64'(cfg_window);
      if (wake_limit < req.now) wake_limit = '1;
      k = 0;
      while (k < ev_count && k < MaxResults && ev_deadline[k] <= wake_limit) begin
        fired_period[k] = ev_period[k];
        fired_client[k] = ev_client[k];
        k++;
      end
      for (j = k; j < ev_count; j++) begin
        ev_deadline[j-k] = ev_deadline[j];
        ev_period[j-k] = ev_period[j];
        ev_client[j-k] = ev_client[j];
      end
      ev_count -= k;
      for (j = 0; j < k; j++) begin
        notice_q.push_back('{ResultWake, fired_client[j], StatusOk, j == k - 1});
        if (fired_period[j] != 0 && ev_count < TableSlots) begin
          insert_event(req.now + 64'(fired_period[j]), fired_period[j], fired_client[j]);
        end
      end
    end
  endfunction

  function automatic void check_field(string what, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic void add_register(logic [3:0] client, logic [31:0] delay,
                                       logic [31:0] period, logic [63:0] now);
    request_q.push_back('{KindRegister, client, delay, period, now});
  endfunction

  function automatic void add_tick(logic [63:0] now);
    request_q.push_back('{KindTick, 4'($urandom), $urandom, $urandom, now});
  endfunction

  function automatic sched_req_t random_request(inout logic [63:0] cursor);
    sched_req_t req;
    int         pick;
    pick = $urandom_range(0, 99);
    req.client = 4'($urandom);
    req.delay = $urandom;
    req.period = $urandom;
    req.now = cursor;
    if (pick < 52) begin
      req.kind = KindRegister;
      pick = $urandom_range(0, 99);
      if (pick < 80) req.delay = $urandom_range(0, 400000);
      else if (pick < 90) req.delay = pick[0] ? 32'hFFFF_FFFF : 32'h0;
      pick = $urandom_range(0, 99);
      if (pick < 45) req.period = 32'h0;
      else if (pick < 88) req.period = $urandom_range(1, 300000);
      else if (pick < 93) req.period = 32'hFFFF_FFFF;
    end else if (pick < 97) begin
      req.kind = KindTick;
      cursor = cursor + 64'($urandom_range(0, 200000));
      req.now = cursor;
    end else begin
      req.kind = 1'($urandom);
      req.now = {$urandom, $urandom};
    end
    return req;
  endfunction

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || notice_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_window(logic [31:0] value);
    @(posedge clk_i);
    window_we <= 1'b1;
    window_data <= value;
    @(posedge clk_i);
    window_we <= 1'b0;
    cfg_window = value;
  endtask

  task automatic run_random_phase(int count, logic [63:0] start, logic long_hold);
    logic [63:0] cursor;
    cursor = start;
    @(negedge clk_i);
    hold_req = long_hold;
    repeat (count) request_q.push_back(random_request(cursor));
    wait_drained();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cur_req <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        run_event_table(cur_req);
      end
      if (!in_valid || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0 && !calm && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          next_req = request_q.pop_front();
          cur_req <= next_req;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (notice_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual client %0d",
                   $time, woken_client_o);
          mismatches++;
        end else begin
          head_notice = notice_q.pop_front();
          check_field("result_kind", 4'(head_notice.rkind), 4'(result_kind_o));
          check_field("woken_client", head_notice.client, woken_client_o);
          check_field("status", 4'(head_notice.status), 4'(status_o));
          check_field("last", 4'(head_notice.last), 4'(last_o));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    window_we = 1'b0;
    window_data = '0;
    in_valid = 1'b0;
    cur_req = '0;
    out_stall = 1'b0;
    mismatches = 0;
    idle_count = 0;
    hold_req = 1'b0;
    calm = 1'b0;
    ev_count = 0;
    cfg_window = EarlyWindowReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_register(4'd0, 32'd0, 32'd0, 64'd0);
    add_tick(64'd0);
    add_tick(64'd0);
    add_register(4'd12, 32'd100000, 32'd0, 64'd0);
    add_register(4'd13, 32'd100001, 32'd0, 64'd0);
    add_tick(64'd0);
    add_tick(64'd1);
    add_register(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_0000);
    add_tick(64'hFFFF_FFFF_FFFF_FFF0);
    add_tick(64'd0);
    for (int c = 1; c <= 7; c++) begin
      add_register(4'(c), 32'd200000, c[0] ? 32'd50000 : 32'd0, 64'd1000);
    end
    add_register(4'd9, 32'd1234, 32'd0, 64'd1000);
    add_tick(64'd150000);
    add_tick(64'd200000);
    add_tick(64'hFFFF_FFFF_FFFF_FFFF);
    add_register(4'd10, 32'd0, 32'd1, 64'd5);
    add_tick(64'd5);
    add_tick(64'd6);
    wait_drained();

    run_random_phase(70, 64'd0, 1'b1);
    write_window(32'd0);
    run_random_phase(50, 64'd5000, 1'b0);
    write_window(32'hFFFF_FFFF);
    run_random_phase(50, 64'hFFFF_FFFF_FFF0_0000, 1'b0);
    write_window($urandom);
    run_random_phase(50, {$urandom, $urandom}, 1'b0);
    write_window(EarlyWindowReset);
    calm = 1'b1;
    run_random_phase(80, 64'd0, 1'b0);

    if (mismatches == 0 && notice_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
